[rtl/varint_msb_first_decoder_defines.svh]
// ----------------------------------------------------------------------------
// varint_msb_first_decoder_defines
// assertion macros used by the varint decoder top level
// ----------------------------------------------------------------------------
`ifndef VARINT_MSB_FIRST_DECODER_DEFINES_SVH
`define VARINT_MSB_FIRST_DECODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define VMFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define VMFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/vmfd_pkg.sv]
// ----------------------------------------------------------------------------
// vmfd_pkg
// types and constants for the msb-first varint decoder
// ----------------------------------------------------------------------------
package vmfd_pkg;

  localparam int unsigned ACC_W   = 64;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned GROUP_W = 7;

  localparam logic [COUNT_W-1:0] MAX_OCTETS = 4'd10;

  localparam logic [BYTE_W-1:0] LEAD_UNSIGNED   = 8'h81;
  localparam logic [BYTE_W-1:0] LEAD_SIGNED_POS = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD_SIGNED_NEG = 8'hff;

  localparam int unsigned CONT_BIT = 7;
  localparam int unsigned SIGN_BIT = 6;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_BAD_LEAD = 2'd3
  } status_t;

  typedef struct packed {
    logic [ACC_W-1:0]   acc;
    logic [COUNT_W-1:0] octets;
    logic [BYTE_W-1:0]  lead;
    logic               sgn;
    logic               discarding;
  } dec_state_t;

  typedef struct packed {
    logic [ACC_W-1:0]   value;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } dec_result_t;

endpackage

[rtl/varint_msb_first_decoder.sv]
// ----------------------------------------------------------------------------
// varint_msb_first_decoder
// msb-first varint decoder, one octet per word, 64-bit results
// ----------------------------------------------------------------------------
// Takes one octet per word and sustains one word per clock cycle as long as
// results are taken when offered; a word that gives a result waits in the
// input register while an earlier result is stalled on the output. An input
// word goes through an input register, then one pass of shift/compare logic
// into the output register; the loop through the accumulator register sets
// this rate. Words that produce no result (continuation octets and dropped
// octets after an error) move on even while the output is stalled.
// Errors give a zero value and count with a nonzero status; after an error
// octets are dropped up to the buffer end.
module varint_msb_first_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // signed_mode
  input  logic        s_axis_tlast,   // buffer_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // decoded_value, octet_count, zero pad
  output logic [1:0]  m_axis_tuser    // status
);
  import vmfd_pkg::*;
  `include "varint_msb_first_decoder_defines.svh"

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_signed;
  logic              in_end;

  dec_state_t  st;
  dec_state_t  st_next;
  logic        emit;
  dec_result_t res;

  logic        out_valid;
  dec_result_t out_res;
  logic        fire;

  vmfd_step u_step (
    .st          (st),
    .data_byte   (in_byte),
    .signed_mode (in_signed),
    .buffer_end  (in_end),
    .st_next     (st_next),
    .emit        (emit),
    .res         (res)
  );

  assign fire          = in_valid && (!out_valid || m_axis_tready || !emit);
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte   <= s_axis_tdata;
      in_signed <= s_axis_tuser;
      in_end    <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_res.count, out_res.value};
  assign m_axis_tuser  = out_res.status;

  `VMFD_ASSERT_NOW(a_octets_max, 1'b1, st.octets <= MAX_OCTETS,
    "octet count ran past ten")
  `VMFD_ASSERT_NOW(a_discard_idle, st.discarding, st.octets == '0,
    "partial integer held while discarding")
  `VMFD_ASSERT_NOW(a_err_zero, out_valid && (out_res.status != ST_OK),
    (out_res.value == '0) && (out_res.count == '0), "error result not zeroed")
  `VMFD_ASSERT_NOW(a_ok_count, out_valid && (out_res.status == ST_OK),
    (out_res.count != '0) && (out_res.count <= MAX_OCTETS), "bad octet count on success")
  `VMFD_ASSERT_NEXT(a_no_overwrite, out_valid && !m_axis_tready,
    out_valid && $stable(out_res), "stalled result overwritten")

endmodule

[rtl/vmfd_step.sv]
// ----------------------------------------------------------------------------
// vmfd_step
// next-state and result logic for one octet of the varint decoder
// ----------------------------------------------------------------------------
module vmfd_step (
  input  vmfd_pkg::dec_state_t               st,
  input  logic [vmfd_pkg::BYTE_W-1:0]        data_byte,
  input  logic                               signed_mode,
  input  logic                               buffer_end,
  output vmfd_pkg::dec_state_t               st_next,
  output logic                               emit,
  output vmfd_pkg::dec_result_t              res
);
  import vmfd_pkg::*;

  logic               first;
  logic [ACC_W-1:0]   acc_base;
  logic [ACC_W-1:0]   acc_shifted;
  logic [BYTE_W-1:0]  lead;
  logic               sgn;
  logic [COUNT_W-1:0] count;
  logic               lead_ok;

  always_comb begin
    first       = (st.octets == '0);
    acc_base    = first ? {ACC_W{signed_mode & data_byte[SIGN_BIT]}} : st.acc;
    lead        = first ? data_byte : st.lead;
    sgn         = first ? signed_mode : st.sgn;
    acc_shifted = {acc_base[ACC_W-GROUP_W-1:0], data_byte[GROUP_W-1:0]};
    count       = st.octets + 4'd1;
    if (sgn) begin
      lead_ok = (lead == LEAD_SIGNED_POS) || (lead == LEAD_SIGNED_NEG);
    end else begin
      lead_ok = (lead == LEAD_UNSIGNED);
    end
  end

  always_comb begin
    st_next    = st;
    emit       = 1'b0;
    res.value  = '0;
    res.count  = '0;
    res.status = ST_OK;
    if (st.discarding) begin
      // drop words up to and including the buffer end
      st_next.discarding = ~buffer_end;
    end else if (st.octets == MAX_OCTETS) begin
      st_next            = '0;
      st_next.discarding = ~buffer_end;
      emit               = 1'b1;
      res.status         = ST_TOO_LONG;
    end else if (data_byte[CONT_BIT]) begin
      if (buffer_end) begin
        st_next    = '0;
        emit       = 1'b1;
        res.status = ST_TRUNC;
      end else begin
        st_next.acc    = acc_shifted;
        st_next.octets = count;
        st_next.lead   = lead;
        st_next.sgn    = sgn;
      end
    end else if ((count == MAX_OCTETS) && !lead_ok) begin
      st_next            = '0;
      st_next.discarding = ~buffer_end;
      emit               = 1'b1;
      res.status         = ST_BAD_LEAD;
    end else begin
      st_next    = '0;
      emit       = 1'b1;
      res.value  = acc_shifted;
      res.count  = count;
      res.status = ST_OK;
    end
  end

endmodule

[verif/varint_msb_first_decoder_tb.sv]
// ----------------------------------------------------------------------------
// varint_msb_first_decoder_tb
// self-checking bench for the msb-first varint decoder: a directed set of
// short, overlong, badly led and truncated integers, then randomly built
// octet streams under changing stall patterns, all scored against an
// in-bench decoder that tracks the same state word by word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module varint_msb_first_decoder_tb;
  import vmfd_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_OCTETS = 410;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // data_byte
  logic        s_axis_tuser = 1'b0; // signed_mode
  logic        s_axis_tlast = 1'b0; // buffer_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // decoded_value, octet_count, zero pad
  logic [1:0]  m_axis_tuser;        // status

  varint_msb_first_decoder DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int tx_idle_pct = 32;
  int rx_idle_pct = 57;
  int mismatches = 0;
  int decoded_octets = 0;
  int stall_cycles = 0;

  // decoder state mirrored in the bench
  logic [63:0] acc_m = '0;
  logic [3:0]  seen_m = '0;
  logic [7:0]  lead_m = '0;
  logic        sgn_m = 1'b0;
  logic        drop_m = 1'b0;

  dec_result_t pending_decodes[$];
  dec_result_t want;

  function automatic void clear_int();
    acc_m = '0;
    seen_m = '0;
    lead_m = '0;
    sgn_m = 1'b0;
  endfunction

  function automatic void abort_int(status_t st, logic last);
    dec_result_t r;
    clear_int();
    drop_m = !last;
    r.value = '0;
    r.count = '0;
    r.status = st;
    pending_decodes.push_back(r);
  endfunction

  function automatic void decode_octet(logic [7:0] b, logic sm, logic last);
    logic [3:0]  cnt;
    logic        lead_ok;
    dec_result_t r;
    if (drop_m) begin
      if (last) drop_m = 1'b0;
      return;
    end
    decoded_octets++;
    if (seen_m == '0) begin
      sgn_m = sm;
      lead_m = b;
      acc_m = (sm && b[SIGN_BIT]) ? '1 : '0;
    end
    cnt = seen_m + 4'd1;
    if (cnt > MAX_OCTETS) begin
      abort_int(ST_TOO_LONG, last);
      return;
    end
    acc_m = {acc_m[ACC_W-GROUP_W-1:0], b[GROUP_W-1:0]};
    if (b[CONT_BIT]) begin
      if (last) abort_int(ST_TRUNC, last);
      else seen_m = cnt;
      return;
    end
    if (cnt == MAX_OCTETS) begin
      if (sgn_m) lead_ok = (lead_m == LEAD_SIGNED_POS) || (lead_m == LEAD_SIGNED_NEG);
      else lead_ok = (lead_m == LEAD_UNSIGNED);
      if (!lead_ok) begin
        abort_int(ST_BAD_LEAD, last);
        return;
      end
    end
    r.value = acc_m;
    r.count = cnt;
    r.status = ST_OK;
    clear_int();
    pending_decodes.push_back(r);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic sm, input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= sm;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    decode_octet(b, sm, last);
  endtask

  // result side: random stalls and scoring
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_decodes.size() == 0) begin
        $error("result word with nothing expected: value %h count %0d status %0d",
               m_axis_tdata[63:0], m_axis_tdata[67:64], m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_decodes.pop_front();
        if (m_axis_tdata[63:0] !== want.value) begin
          $error("decoded_value: expected %h, got %h", want.value, m_axis_tdata[63:0]);
          mismatches++;
        end
        if (m_axis_tdata[67:64] !== want.count) begin
          $error("octet_count: expected %0d, got %0d", want.count, m_axis_tdata[67:64]);
          mismatches++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          mismatches++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_short_values();
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h7f, 1'b1, 1'b1);  // signed, all ones, terminator at buffer end
    send_byte(8'h3f, 1'b1, 1'b0);
  endtask

  task automatic test_overlong();
    // eleven continuation octets, error lands on the buffer end so nothing is dropped
    send_byte(8'hff, 1'b1, 1'b0);
    for (int i = 0; i < 9; i++) send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'hff, 1'b1, 1'b1);
    send_byte(8'h05, 1'b0, 1'b0);
  endtask

  task automatic test_bad_lead_and_drop();
    // 0x80 leads a valid signed integer but not an unsigned one
    send_byte(8'h80, 1'b0, 1'b0);
    for (int i = 0; i < 8; i++) send_byte(8'haa, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'h34, 1'b1, 1'b1);
  endtask

  task automatic test_truncated();
    send_byte(8'hc0, 1'b1, 1'b1);
    send_byte(8'h01, 1'b0, 1'b0);
  endtask

  task automatic send_random_int();
    int          pick;
    int          len;
    logic        sm;
    logic [7:0]  b;
    logic        last;
    // finish off any discard so the integer below is actually decoded
    while (drop_m) send_byte(8'($urandom_range(0, 255)), 1'($urandom), $urandom_range(0, 2) == 0);
    pick = $urandom_range(0, 99);
    sm = 1'($urandom);
    if (pick >= 85) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++)
        send_byte(8'($urandom_range(0, 255)), 1'($urandom), $urandom_range(0, 3) == 0);
      return;
    end
    if (pick < 60) len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
    else if (pick < 75) len = 10;
    else len = $urandom_range(11, 12);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      b[CONT_BIT] = (i < len - 1) || (len > int'(MAX_OCTETS));
      if (len == 10 && i == 0 && $urandom_range(0, 2) != 0) begin
        if (!sm) b = LEAD_UNSIGNED;
        else b = $urandom_range(0, 1) ? LEAD_SIGNED_POS : LEAD_SIGNED_NEG;
      end
      if (i == len - 1) last = ($urandom_range(0, 3) == 0);
      else last = ($urandom_range(0, 39) == 0);
      // signed_mode only counts on the first octet; vary it elsewhere
      send_byte(b, (i == 0) ? sm : 1'($urandom), last);
    end
  endtask

  task automatic test_random_stream(input int octets);
    int goal;
    goal = decoded_octets + octets;
    while (decoded_octets < goal) send_random_int();
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 6; i++) send_random_int();
    s_axis_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    for (int i = 0; i < 6; i++) send_random_int();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 32;
    rx_idle_pct = 57;
    test_short_values();
    test_overlong();
    test_bad_lead_and_drop();
    test_truncated();
    test_random_stream(PHASE_OCTETS);

    tx_idle_pct = 57;
    rx_idle_pct = 32;
    test_drain_pause();
    test_random_stream(PHASE_OCTETS);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_stream(PHASE_OCTETS);

    s_axis_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_decodes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
